/* rtl/blm_pkg.sv */
// Shared types and constants for the battery level monitor.
`default_nettype none
package blm_pkg;

  localparam int MV_W   = 13;
  localparam int PCT_W  = 7;
  localparam int RUN_W  = 4;
  localparam int CIDX_W = 3;
  localparam int CDAT_W = 13;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // Register indexes of the configuration port.
  localparam logic [CIDX_W-1:0] CFG_PRESENT_MIN_MV  = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LOW_LEVEL       = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_CRITICAL_LEVEL  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_LOW_REARM_LEVEL = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_CONFIRM_COUNT   = 3'd4;

  localparam logic [MV_W-1:0]  RST_PRESENT_MIN_MV  = 13'd2500;
  localparam logic [PCT_W-1:0] RST_LOW_LEVEL       = 7'd15;
  localparam logic [PCT_W-1:0] RST_CRITICAL_LEVEL  = 7'd5;
  localparam logic [PCT_W-1:0] RST_LOW_REARM_LEVEL = 7'd20;
  localparam logic [RUN_W-1:0] RST_CONFIRM_COUNT   = 4'd3;

  // Request codes.
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TAKE   = 1'b1;

  typedef struct packed {
    logic [MV_W-1:0]  present_min_mv;
    logic [PCT_W-1:0] low_level;
    logic [PCT_W-1:0] critical_level;
    logic [PCT_W-1:0] low_rearm_level;
    logic [RUN_W-1:0] confirm_count;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic [MV_W-1:0]  millivolts;
    logic [PCT_W-1:0] raw_percent;
    logic             charging_in;
  } item_t;

  typedef struct packed {
    logic [PCT_W-1:0] smoothed_percent;
    logic             present_flag;
    logic             low_flag;
    logic             critical_flag;
    logic             low_notice;
    logic             absent_notice;
    logic             shutdown_request;
  } res_t;

  typedef struct packed {
    logic [PCT_W-1:0] filtered_level;
    logic             have_history;
    logic             low_told;
    logic             absent_told;
    logic             critical_latched;
    logic [RUN_W-1:0] critical_run;
  } state_t;

endpackage
`default_nettype wire

/* rtl/blm_if.sv */
// Handshake channel interfaces for monitor requests and results.
`default_nettype none
interface blm_in_if
  import blm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [MV_W-1:0]  millivolts;
  logic [PCT_W-1:0] raw_percent;
  logic             charging_in;

  modport source (output valid, req_type, millivolts, raw_percent, charging_in,
                  input ready);
  modport sink (input valid, req_type, millivolts, raw_percent, charging_in,
                output ready);
endinterface

interface blm_out_if
  import blm_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [PCT_W-1:0] smoothed_percent;
  logic             present_flag;
  logic             low_flag;
  logic             critical_flag;
  logic             low_notice;
  logic             absent_notice;
  logic             shutdown_request;

  modport source (output valid, smoothed_percent, present_flag, low_flag,
                  critical_flag, low_notice, absent_notice, shutdown_request,
                  input ready);
  modport sink (input valid, smoothed_percent, present_flag, low_flag,
                critical_flag, low_notice, absent_notice, shutdown_request,
                output ready);
endinterface
`default_nettype wire

/* rtl/blm_cfg_regs.sv */
// Configuration register file with write-only access.
`default_nettype none
module blm_cfg_regs
  import blm_pkg::*;
(
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_we,
  input  wire  [CIDX_W-1:0] cfg_index,
  input  wire  [CDAT_W-1:0] cfg_wdata,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_PRESENT_MIN_MV:  cfg_nxt.present_min_mv  = cfg_wdata[MV_W-1:0];
        CFG_LOW_LEVEL:       cfg_nxt.low_level       = cfg_wdata[PCT_W-1:0];
        CFG_CRITICAL_LEVEL:  cfg_nxt.critical_level  = cfg_wdata[PCT_W-1:0];
        CFG_LOW_REARM_LEVEL: cfg_nxt.low_rearm_level = cfg_wdata[PCT_W-1:0];
        CFG_CONFIRM_COUNT:   cfg_nxt.confirm_count   = cfg_wdata[RUN_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.present_min_mv  <= RST_PRESENT_MIN_MV;
      cfg_r.low_level       <= RST_LOW_LEVEL;
      cfg_r.critical_level  <= RST_CRITICAL_LEVEL;
      cfg_r.low_rearm_level <= RST_LOW_REARM_LEVEL;
      cfg_r.confirm_count   <= RST_CONFIRM_COUNT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* rtl/blm_update.sv */
// Per-item filter, flag, notice and shutdown-latch logic.
`default_nettype none
module blm_update
  import blm_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  item_t  item,
  output state_t st_nxt,
  output res_t   res
);

  logic [PCT_W-1:0] raw_clamped;
  logic [PCT_W+2:0] blend;
  logic [PCT_W-1:0] level;
  logic             present;
  logic             low;
  logic             crit;
  logic [RUN_W-1:0] run_inc;

  always_comb begin
    raw_clamped = (item.raw_percent > PCT_MAX) ? PCT_MAX : item.raw_percent;
    // 3*old + new + 2 fits in ten bits; the divide by four is a shift.
    blend = {3'b000, st.filtered_level} + {2'b00, st.filtered_level, 1'b0}
          + {3'b000, raw_clamped} + 10'd2;
    level   = st.have_history ? blend[PCT_W+1:2] : raw_clamped;
    present = item.millivolts >= cfg.present_min_mv;
    low     = present && (level <= cfg.low_level);
    crit    = present && (level <= cfg.critical_level);
    run_inc = (st.critical_run < cfg.confirm_count) ? st.critical_run + 4'd1
                                                    : st.critical_run;

    st_nxt = st;
    res    = '0;
    if (item.req_type == REQ_TAKE) begin
      res.smoothed_percent    = st.filtered_level;
      res.shutdown_request    = st.critical_latched;
      st_nxt.critical_latched = 1'b0;
    end else begin
      st_nxt.filtered_level = level;
      st_nxt.have_history   = 1'b1;
      res.smoothed_percent  = level;
      res.present_flag      = present;
      res.low_flag          = low;
      res.critical_flag     = crit;
      res.low_notice        = low && !item.charging_in && !st.low_told;
      res.absent_notice     = !present && !st.absent_told;

      // Re-arm wins over a notice sent in the same sample.
      if (level >= cfg.low_rearm_level || item.charging_in) begin
        st_nxt.low_told = 1'b0;
      end else if (res.low_notice) begin
        st_nxt.low_told = 1'b1;
      end
      st_nxt.absent_told = !present;

      if (crit && !item.charging_in) begin
        st_nxt.critical_run = run_inc;
        if (run_inc >= cfg.confirm_count) begin
          st_nxt.critical_latched = 1'b1;
        end
      end else begin
        st_nxt.critical_run = '0;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/battery_level_monitor_core.sv */
// Battery level monitor top level: input register, update logic, result register.
`default_nettype none
// Each beat on in_ch is either a battery sample or a take request for the
// latched shutdown request, and yields exactly one result beat on out_ch.
// An accepted beat is held in an input register, passes through the update
// logic into the result register, and the monitor state is written in the
// same cycle as the result register, so one beat per cycle is sustained
// while out_ch does not stall. A result reaches out_ch through the input
// register and then the result register. The result register holds a
// result while out_ch stalls, and the input register still takes one
// more beat meanwhile. Configuration writes on cfg_we/cfg_index/cfg_wdata take
// effect at the next edge; indexes beyond the last register are ignored.
module battery_level_monitor_core
  import blm_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  blm_in_if.sink                in_ch,
  blm_out_if.source             out_ch,
  input  wire                   cfg_we,
  input  wire [CIDX_W-1:0]      cfg_index,
  input  wire [CDAT_W-1:0]      cfg_wdata
);

  cfg_t   cfg;
  item_t  in_r;
  logic   in_valid_r;
  res_t   out_r;
  logic   out_valid_r;
  state_t state_r;
  state_t state_nxt;
  res_t   res_nxt;
  logic   advance;
  logic   in_take;

  blm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  blm_update u_update (
    .cfg    (cfg),
    .st     (state_r),
    .item   (in_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.req_type    <= in_ch.req_type;
      in_r.millivolts  <= in_ch.millivolts;
      in_r.raw_percent <= in_ch.raw_percent;
      in_r.charging_in <= in_ch.charging_in;
    end
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.smoothed_percent = out_r.smoothed_percent;
  assign out_ch.present_flag     = out_r.present_flag;
  assign out_ch.low_flag         = out_r.low_flag;
  assign out_ch.critical_flag    = out_r.critical_flag;
  assign out_ch.low_notice       = out_r.low_notice;
  assign out_ch.absent_notice    = out_r.absent_notice;
  assign out_ch.shutdown_request = out_r.shutdown_request;

`ifndef SYNTHESIS
  a_low_notice_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.low_notice |-> out_r.low_flag && out_r.present_flag)
    else $error("low notice without a low, present battery");

  a_absent_notice: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.absent_notice |-> !out_r.present_flag)
    else $error("absent notice while battery present");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.smoothed_percent <= PCT_MAX)
    else $error("smoothed percent out of range");

  a_history: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_r.req_type == REQ_SAMPLE) |=> state_r.have_history)
    else $error("sample did not set the history bit");

  a_take_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_r.req_type == REQ_TAKE) |=> !state_r.critical_latched)
    else $error("take request left the shutdown latch set");
`endif

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the battery level monitor core.
`timescale 1ns / 1ps
module tb_top;
  import blm_pkg::*;

  typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_mode_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CIDX_W-1:0]   cfg_index;
  logic [CDAT_W-1:0]   cfg_wdata;

  blm_in_if  in_ch ();
  blm_out_if out_ch ();

  battery_level_monitor_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted monitor state and thresholds.
  state_t   mon_st;
  cfg_t     cfg_model;
  res_t     pending_status[$];
  int       mismatch_cnt;

  // Sender and receiver pacing.
  int       burst_left;
  bit       no_gaps;
  int       hold_left;
  int       rx_seg_left;
  int       rx_phase;
  rx_mode_t rx_mode;

  // Simulated battery driving the well-formed sample stream.
  int       batt_level;
  bit       on_charger;
  bit       batt_in;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic res_t predict_status(item_t it);
    res_t             r;
    logic [PCT_W-1:0] raw;
    logic             present;
    logic             low;
    logic             crit;
    r = '0;
    if (it.req_type == REQ_TAKE) begin
      r.smoothed_percent = mon_st.filtered_level;
      r.shutdown_request = mon_st.critical_latched;
      mon_st.critical_latched = 1'b0;
      return r;
    end
    raw = (it.raw_percent > PCT_MAX) ? PCT_MAX : it.raw_percent;
    present = it.millivolts >= cfg_model.present_min_mv;
    if (mon_st.have_history) begin
      mon_st.filtered_level = PCT_W'((32'd3 * mon_st.filtered_level + raw + 32'd2) >> 2);
    end else begin
      mon_st.filtered_level = raw;
    end
    mon_st.have_history = 1'b1;
    low  = present && (mon_st.filtered_level <= cfg_model.low_level);
    crit = present && (mon_st.filtered_level <= cfg_model.critical_level);
    if (low && !it.charging_in && !mon_st.low_told) begin
      r.low_notice = 1'b1;
      mon_st.low_told = 1'b1;
    end
    if (!present && !mon_st.absent_told) begin
      r.absent_notice = 1'b1;
      mon_st.absent_told = 1'b1;
    end
    if (present) mon_st.absent_told = 1'b0;
    // The re-arm test runs after the notice, so both can happen in one sample.
    if (mon_st.filtered_level >= cfg_model.low_rearm_level || it.charging_in) begin
      mon_st.low_told = 1'b0;
    end
    if (crit && !it.charging_in) begin
      if (mon_st.critical_run < cfg_model.confirm_count) begin
        mon_st.critical_run = mon_st.critical_run + 1'b1;
      end
      if (mon_st.critical_run >= cfg_model.confirm_count) mon_st.critical_latched = 1'b1;
    end else begin
      mon_st.critical_run = '0;
    end
    r.smoothed_percent = mon_st.filtered_level;
    r.present_flag     = present;
    r.low_flag         = low;
    r.critical_flag    = crit;
    return r;
  endfunction

  function automatic string fmt_status(res_t r);
    return $sformatf("pct=%0d present=%b low=%b crit=%b low_ntc=%b absent_ntc=%b shutdown=%b",
                     r.smoothed_percent, r.present_flag, r.low_flag, r.critical_flag,
                     r.low_notice, r.absent_notice, r.shutdown_request);
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Result checker: every accepted result beat is matched to the oldest prediction.
  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got = {out_ch.smoothed_percent, out_ch.present_flag, out_ch.low_flag,
             out_ch.critical_flag, out_ch.low_notice, out_ch.absent_notice,
             out_ch.shutdown_request};
      if (pending_status.size() == 0) begin
        report_mismatch({"unexpected result: ", fmt_status(got)});
      end else begin
        want = pending_status.pop_front();
        if (got !== want) begin
          report_mismatch({"expected ", fmt_status(want), " got ", fmt_status(got)});
        end
      end
    end
  end

  // Result receiver: changing stall patterns, plus a long hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        if (rx_seg_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          rx_seg_left = $urandom_range(20, 150);
        end
        rx_seg_left--;
        rx_phase++;
        case (rx_mode)
          RX_FREE: begin
            out_ch.ready <= 1'b1;
          end
          RX_RANDOM: begin
            out_ch.ready <= ($urandom_range(0, 99) >= 35);
          end
          default: begin
            out_ch.ready <= ((rx_phase % 7) < 4);
          end
        endcase
      end
    end
  end

  // Offers one beat, waits for it to be taken and records its prediction.
  task automatic send_beat(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 30);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.req_type    <= it.req_type;
    in_ch.millivolts  <= it.millivolts;
    in_ch.raw_percent <= it.raw_percent;
    in_ch.charging_in <= it.charging_in;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_status.push_back(predict_status(it));
  endtask

  task automatic send_sample(input int mv, input int raw, input bit chg);
    item_t it;
    it.req_type    = REQ_SAMPLE;
    it.millivolts  = MV_W'(mv);
    it.raw_percent = PCT_W'(raw);
    it.charging_in = chg;
    send_beat(it);
  endtask

  task automatic send_take();
    item_t it;
    it.req_type    = REQ_TAKE;
    it.millivolts  = MV_W'($urandom);
    it.raw_percent = PCT_W'($urandom);
    it.charging_in = 1'($urandom);
    send_beat(it);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic put_reg(input logic [CIDX_W-1:0] idx, input int data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CDAT_W'(data);
    @(posedge clk);
  endtask

  // Only called with the block idle.
  task automatic set_thresholds(input cfg_t c);
    put_reg(CFG_PRESENT_MIN_MV, c.present_min_mv);
    put_reg(CFG_LOW_LEVEL, c.low_level);
    put_reg(CFG_CRITICAL_LEVEL, c.critical_level);
    put_reg(CFG_LOW_REARM_LEVEL, c.low_rearm_level);
    put_reg(CFG_CONFIRM_COUNT, c.confirm_count);
    cfg_we <= 1'b0;
    cfg_model = c;
  endtask

  function automatic cfg_t rand_thresholds();
    cfg_t c;
    int   lo;
    int   rearm;
    c.present_min_mv = ($urandom_range(0, 9) == 0) ? MV_W'($urandom_range(0, 8191))
                                                   : MV_W'($urandom_range(2000, 4000));
    lo = $urandom_range(3, 40);
    rearm = lo + $urandom_range(0, 25);
    c.low_level       = PCT_W'(lo);
    c.critical_level  = PCT_W'($urandom_range(0, lo));
    c.low_rearm_level = PCT_W'((rearm > 100) ? 100 : rearm);
    c.confirm_count   = ($urandom_range(0, 9) == 0) ? '0 : RUN_W'($urandom_range(1, 15));
    return c;
  endfunction

  // Mostly a slowly draining and recharging battery, with some take requests
  // and some items with arbitrary field values.
  function automatic item_t next_walk_item();
    item_t it;
    int    pick;
    int    raw;
    int    lo;
    int    span;
    pick = $urandom_range(0, 99);
    it.req_type    = REQ_SAMPLE;
    it.millivolts  = MV_W'($urandom);
    it.raw_percent = PCT_W'($urandom);
    it.charging_in = 1'($urandom);
    if (pick < 8) begin
      it.req_type = REQ_TAKE;
      return it;
    end
    if (pick < 14) return it;
    if (on_charger) begin
      batt_level += int'($urandom_range(0, 4));
      if (batt_level > 100) batt_level = 100;
      if ((batt_level >= 90 && $urandom_range(0, 3) == 0) || $urandom_range(0, 29) == 0) begin
        on_charger = 1'b0;
      end
    end else begin
      batt_level -= int'($urandom_range(0, 3));
      if (batt_level < 0) batt_level = 0;
      if ($urandom_range(0, 24) == 0 || (batt_level == 0 && $urandom_range(0, 5) == 0)) begin
        on_charger = 1'b1;
      end
    end
    if ($urandom_range(0, 29) == 0) batt_in = !batt_in;
    lo = cfg_model.present_min_mv;
    if (batt_in) begin
      span = (8191 - lo > 600) ? 600 : 8191 - lo;
      it.millivolts = MV_W'(lo + int'($urandom_range(0, span)));
    end else begin
      it.millivolts = (lo == 0) ? '0 : MV_W'($urandom_range(0, lo - 1));
    end
    raw = batt_level + int'($urandom_range(0, 4)) - 2;
    if (raw < 0) raw = 0;
    if (raw > 100) raw = 100;
    it.raw_percent = PCT_W'(raw);
    it.charging_in = on_charger;
    return it;
  endfunction

  // Reset thresholds: first sample, clamping, presence edge, low notice,
  // critical latch after three samples, take requests and charging re-arm.
  task automatic test_default_thresholds();
    send_take();
    send_sample(8191, 127, 1'b0);
    send_sample(0, 0, 1'b1);
    send_sample(2499, 0, 1'b0);
    send_sample(2500, 0, 1'b0);
    repeat (13) send_sample(4000, 0, 1'b0);
    send_take();
    send_take();
    send_sample(5461, 0, 1'b1);
    send_sample(2730, 0, 1'b0);
    send_sample(4000, 100, 1'b0);
  endtask

  task automatic test_threshold_extremes();
    cfg_t c;
    wait_idle();
    // Everything counts as low and critical, re-arm is always met, and a
    // zero confirm count latches on the first critical sample.
    c.present_min_mv = '0;
    c.low_level = PCT_MAX;
    c.critical_level = PCT_MAX;
    c.low_rearm_level = '0;
    c.confirm_count = '0;
    set_thresholds(c);
    send_sample(0, 50, 1'b0);
    send_sample(100, 60, 1'b0);
    send_take();
    repeat (20) send_beat(next_walk_item());
    wait_idle();
    c.present_min_mv = 13'd8191;
    c.low_level = '0;
    c.critical_level = '0;
    c.low_rearm_level = PCT_MAX;
    c.confirm_count = 4'd15;
    set_thresholds(c);
    send_sample(8191, 0, 1'b0);
    send_sample(8190, 0, 1'b0);
    send_sample(8191, 0, 1'b1);
    send_take();
    wait_idle();
    // The filter settles at 2 with a zero input, so that is the level to trip.
    c.present_min_mv = 13'd1;
    c.low_level = 7'd2;
    c.critical_level = 7'd2;
    set_thresholds(c);
    repeat (34) send_sample(8191, 0, 1'b0);
    send_take();
    send_sample(0, 0, 1'b0);
  endtask

  // Results back up while the receiver holds off; input must stall, not drop.
  task automatic test_output_stall();
    wait_idle();
    hold_left = 60;
    no_gaps = 1'b1;
    repeat (24) send_beat(next_walk_item());
    no_gaps = 1'b0;
    wait_idle();
  endtask

  task automatic test_battery_walk();
    repeat (6) begin
      wait_idle();
      set_thresholds(rand_thresholds());
      repeat (105) send_beat(next_walk_item());
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= '0;
    cfg_wdata         <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.req_type    <= REQ_SAMPLE;
    in_ch.millivolts  <= '0;
    in_ch.raw_percent <= '0;
    in_ch.charging_in <= 1'b0;
    mon_st = '0;
    cfg_model.present_min_mv  = RST_PRESENT_MIN_MV;
    cfg_model.low_level       = RST_LOW_LEVEL;
    cfg_model.critical_level  = RST_CRITICAL_LEVEL;
    cfg_model.low_rearm_level = RST_LOW_REARM_LEVEL;
    cfg_model.confirm_count   = RST_CONFIRM_COUNT;
    mismatch_cnt = 0;
    burst_left = 0;
    no_gaps = 1'b0;
    hold_left = 0;
    rx_seg_left = 0;
    rx_phase = 0;
    batt_level = 100;
    on_charger = 1'b0;
    batt_in = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_thresholds();
    test_threshold_extremes();
    test_output_stall();
    test_battery_walk();

    wait_idle();
    repeat (6) @(posedge clk);
    if (mismatch_cnt == 0 && pending_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
